### hw/rtl/cde_pkg.sv
package cde_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned EPOCH_W  = 32;
    localparam int unsigned CFG_W    = 8;

    // Days since 1970-01-01 held for dates inside the accepted window.
    localparam int unsigned DAYS_W   = 16;
    // Seconds into the day, 0 to 86399.
    localparam int unsigned TOD_W    = 17;
    // Signed offset in seconds, -43200 to 50400.
    localparam int unsigned OFFS_W   = 17;

    localparam logic [EPOCH_W-1:0] EPOCH_LOW  = 32'd1704067200;
    localparam logic [EPOCH_W-1:0] EPOCH_HIGH = 32'd4102444800;

    localparam logic [CFG_W-1:0] OFFSET_MAX  = 8'd104;
    localparam logic [CFG_W-1:0] OFFSET_BIAS = 8'd48;

    // Cumulative days before each month of a year that starts in March.
    function automatic logic [8:0] t_month_days(input logic [MONTH_W-1:0] mp);
        logic [8:0] res;
        case (mp)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

### hw/rtl/cde_if.sv
interface cde_in_if import cde_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;

    modport source (output valid, year, month, day, hour, minute, second, input ready);
    modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface cde_out_if import cde_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               fields_ok;
    logic               epoch_ok;
    logic [EPOCH_W-1:0] utc_epoch;
    logic [EPOCH_W-1:0] local_epoch;

    modport source (output valid, fields_ok, epoch_ok, utc_epoch, local_epoch, input ready);
    modport sink   (input valid, fields_ok, epoch_ok, utc_epoch, local_epoch, output ready);
endinterface

interface cde_cfg_if import cde_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hw/rtl/civil_date_to_epoch.sv
// Civil date to Unix epoch converter.
// A request on i_in carries one UTC calendar reading (year, month, day, hour,
// minute, second). For each accepted request exactly one result request
// appears on o_out with the field check flag, the window check flag, the UTC
// epoch in seconds and the local epoch. Both epoch values read zero whenever
// the window check fails.
// i_cfg writes the biased quarter-hour UTC offset. It is always ready, and it
// should only be written while no request is in flight.
// A request passes through three registers on its way to o_out.valid: an
// input register, a register after the calendar arithmetic and the result
// register. While o_out.ready is high the pipeline takes a new request every
// cycle; the one constant multiply by 86400 in stage 2 sets the clock period.
// When the receiver holds o_out.ready low, the result register holds and each
// stage fills in turn, so three requests can be in flight before i_in.ready
// falls. Nothing is lost or repeated while stalled.
// Reset (synchronous, active low) empties the pipeline and sets the offset to
// the unbiased value, i.e. local time equals UTC.
module civil_date_to_epoch
    import cde_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    cde_in_if.sink   i_in,
    cde_cfg_if.sink  i_cfg,
    cde_out_if.source o_out
);

    // Pipeline control. Each stage moves when the one after it is empty or
    // moving at the same edge.
    logic r_v0, r_v1, r_v2;
    logic adv0, adv1, adv2;

    assign adv2 = !r_v2 || o_out.ready;
    assign adv1 = !r_v1 || adv2;
    assign adv0 = !r_v0 || adv1;

    assign i_in.ready  = adv0;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv0) begin
                r_v0 <= i_in.valid;
            end
            if (adv1) begin
                r_v1 <= r_v0;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // The offset register holds the offset already scaled to seconds, so the
    // last stage only needs an add.
    logic        [CFG_W-1:0]  cfg_clamped;
    logic signed [7:0]        cfg_quarters;
    logic signed [OFFS_W-1:0] cfg_quarters_ext;
    logic signed [OFFS_W-1:0] n_offset;
    logic signed [OFFS_W-1:0] r_offset;

    always_comb begin
        cfg_clamped      = (i_cfg.data <= OFFSET_MAX) ? i_cfg.data : OFFSET_BIAS;
        cfg_quarters     = $signed(cfg_clamped) - $signed(OFFSET_BIAS);
        cfg_quarters_ext = OFFS_W'(cfg_quarters);
        n_offset         = cfg_quarters_ext * 17'sd900;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg.valid) begin
            r_offset <= n_offset;
        end
    end

    // Stage 0: input register.
    logic [YEAR_W-1:0]   r_year;
    logic [MONTH_W-1:0]  r_month;
    logic [DAY_W-1:0]    r_day;
    logic [HOUR_W-1:0]   r_hour;
    logic [MINUTE_W-1:0] r_minute;
    logic [SECOND_W-1:0] r_second;

    always_ff @(posedge i_clk) begin
        if (adv0 && i_in.valid) begin
            r_year   <= i_in.year;
            r_month  <= i_in.month;
            r_day    <= i_in.day;
            r_hour   <= i_in.hour;
            r_minute <= i_in.minute;
            r_second <= i_in.second;
        end
    end

    // Stage 1: field checks and days since 1970.
    // Every date in the window falls in the 400-year era that starts with
    // March 2000, and its year of era stays below 100, so the century terms of
    // the general method vanish. The day count is then
    // 11017 + 365 * yoe + yoe / 4 + day of year, where 11017 is 2000-03-01.
    // Outside the window the result is masked to zero, so the reduced form
    // never shows. The window itself reduces to a year range: even with day
    // overflow a date in 2023 cannot reach 2024, and 2100-01-01 is excluded.
    logic                  fok;
    logic                  eok;
    logic                  jan_feb;
    logic [YEAR_W-1:0]     year_of_era;
    logic [6:0]            yoe;
    logic [MONTH_W-1:0]    mp;
    logic [DAYS_W-1:0]     n_days;
    logic [TOD_W-1:0]      n_tod;

    always_comb begin
        fok = (r_second < 6'd60) && (r_minute < 6'd60) && (r_hour < 5'd24) &&
              (r_day >= 5'd1) && (r_month >= 4'd1) && (r_month <= 4'd12);
        eok = fok && (r_year >= 14'd2024) && (r_year <= 14'd2099);

        jan_feb     = (r_month <= 4'd2);
        year_of_era = r_year - 14'd2000 - {13'd0, jan_feb};
        yoe         = year_of_era[6:0];
        mp          = jan_feb ? (r_month + 4'd9) : (r_month - 4'd3);

        n_days = 16'd11017 + (DAYS_W'(yoe) * 16'd365) + DAYS_W'(yoe[6:2]) +
                 DAYS_W'(t_month_days(mp)) + DAYS_W'(r_day) - 16'd1;
        n_tod  = (TOD_W'(r_hour) * 17'd3600) + (TOD_W'(r_minute) * 17'd60) +
                 TOD_W'(r_second);
    end

    logic              r_fok1;
    logic              r_eok1;
    logic [DAYS_W-1:0] r_days;
    logic [TOD_W-1:0]  r_tod;

    always_ff @(posedge i_clk) begin
        if (adv1 && r_v0) begin
            r_fok1 <= fok;
            r_eok1 <= eok;
            r_days <= n_days;
            r_tod  <= n_tod;
        end
    end

    // Stage 2: seconds, local offset and masking.
    logic [DAYS_W+TOD_W-1:0] day_secs;
    logic [EPOCH_W-1:0]      utc;
    logic [EPOCH_W-1:0]      loc;

    always_comb begin
        day_secs = (DAYS_W+TOD_W)'(r_days) * 33'd86400;
        utc      = day_secs[EPOCH_W-1:0] + EPOCH_W'(r_tod);
        loc      = utc + EPOCH_W'(r_offset);
    end

    logic               r_fok2;
    logic               r_eok2;
    logic [EPOCH_W-1:0] r_utc;
    logic [EPOCH_W-1:0] r_loc;

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r_fok2 <= r_fok1;
            r_eok2 <= r_eok1;
            r_utc  <= r_eok1 ? utc : '0;
            r_loc  <= r_eok1 ? loc : '0;
        end
    end

    assign o_out.valid       = r_v2;
    assign o_out.fields_ok   = r_fok2;
    assign o_out.epoch_ok    = r_eok2;
    assign o_out.utc_epoch   = r_utc;
    assign o_out.local_epoch = r_loc;

endmodule

### hw/rtl/cde_checker.sv
module cde_checker
    import cde_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_fields_ok,
    input logic               i_epoch_ok,
    input logic [EPOCH_W-1:0] i_utc_epoch,
    input logic [EPOCH_W-1:0] i_local_epoch
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // The window check never passes on bad fields.
    a_ok_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_epoch_ok |-> i_fields_ok)
        else $error("epoch_ok without fields_ok");

    // A rejected reading carries zero epochs.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_epoch_ok |-> (i_utc_epoch == '0) && (i_local_epoch == '0))
        else $error("nonzero epoch on rejected reading");

    // An accepted epoch lies inside the window.
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_epoch_ok |-> (i_utc_epoch >= EPOCH_LOW) && (i_utc_epoch < EPOCH_HIGH))
        else $error("accepted epoch outside window");

    // Reset empties the result register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind civil_date_to_epoch cde_checker u_cde_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_fields_ok   (o_out.fields_ok),
    .i_epoch_ok    (o_out.epoch_ok),
    .i_utc_epoch   (o_out.utc_epoch),
    .i_local_epoch (o_out.local_epoch)
);

### dv/civil_date_to_epoch_tb.sv
module civil_date_to_epoch_tb;
    import cde_pkg::*;

    // A run ends as failed once this many cycles pass without any request moving.
    localparam int unsigned STALL_LIMIT = 2000;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } t_reading;

    typedef struct packed {
        logic               fields_ok;
        logic               epoch_ok;
        logic [EPOCH_W-1:0] utc_epoch;
        logic [EPOCH_W-1:0] local_epoch;
    } t_stamp;

    logic clk;
    logic rst_n;

    cde_in_if  date_if ();
    cde_cfg_if offset_if ();
    cde_out_if stamp_if ();

    civil_date_to_epoch u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (date_if),
        .i_cfg   (offset_if),
        .o_out   (stamp_if)
    );

    t_stamp           expected_stamps[$];
    logic [CFG_W-1:0] offset_setting;
    int unsigned      mismatches = 0;
    int unsigned      stall_cycles;
    int unsigned      src_idle_pct;
    int unsigned      sink_idle_pct;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Days since 1970-01-01 by the days-from-civil method: 400-year eras whose
    // years start in March, so the leap day falls at the end of each year.
    function automatic longint days_since_1970(longint y, longint m, longint d);
        longint era;
        longint yoe;
        longint mp;
        longint doy;
        longint doe;
        if (m <= 2) begin
            y = y - 1;
        end
        era = (y >= 0 ? y : y - 399) / 400;
        yoe = y - era * 400;
        mp  = (m > 2) ? m - 3 : m + 9;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic t_stamp epoch_of_reading(t_reading r, logic [CFG_W-1:0] offs);
        t_stamp           s;
        longint           secs;
        longint           local_secs;
        logic [CFG_W-1:0] clamped;
        s = '0;
        s.fields_ok = (r.second < 60) && (r.minute < 60) && (r.hour < 24) &&
                      (r.day >= 1) && (r.month >= 1) && (r.month <= 12);
        if (s.fields_ok) begin
            secs = days_since_1970(longint'(r.year), longint'(r.month), longint'(r.day)) * 86400
                   + longint'(r.hour) * 3600 + longint'(r.minute) * 60 + longint'(r.second);
            s.epoch_ok = (secs >= longint'(EPOCH_LOW)) && (secs < longint'(EPOCH_HIGH));
            if (s.epoch_ok) begin
                // Offsets past the top of the range fall back to plain UTC.
                clamped     = (offs <= OFFSET_MAX) ? offs : OFFSET_BIAS;
                local_secs  = secs + (longint'(clamped) - longint'(OFFSET_BIAS)) * 900;
                s.utc_epoch   = secs[EPOCH_W-1:0];
                s.local_epoch = local_secs[EPOCH_W-1:0];
            end
        end
        return s;
    endfunction

    function automatic t_reading make_reading(int unsigned y, int unsigned mo, int unsigned d,
                                              int unsigned h, int unsigned mi, int unsigned s);
        t_reading r;
        r.year   = YEAR_W'(y);
        r.month  = MONTH_W'(mo);
        r.day    = DAY_W'(d);
        r.hour   = HOUR_W'(h);
        r.minute = MINUTE_W'(mi);
        r.second = SECOND_W'(s);
        return r;
    endfunction

    // Mostly well-formed readings around the window, with a share of readings
    // that are valid outside it and a share of raw bit patterns.
    function automatic t_reading random_reading();
        t_reading r;
        case ($urandom_range(0, 9))
            0, 1: begin
                r.year   = YEAR_W'($urandom_range(0, (1 << YEAR_W) - 1));
                r.month  = MONTH_W'($urandom_range(0, (1 << MONTH_W) - 1));
                r.day    = DAY_W'($urandom_range(0, (1 << DAY_W) - 1));
                r.hour   = HOUR_W'($urandom_range(0, (1 << HOUR_W) - 1));
                r.minute = MINUTE_W'($urandom_range(0, (1 << MINUTE_W) - 1));
                r.second = SECOND_W'($urandom_range(0, (1 << SECOND_W) - 1));
            end
            2: begin
                r = make_reading($urandom_range(0, (1 << YEAR_W) - 1), $urandom_range(1, 12),
                                 $urandom_range(1, 31), $urandom_range(0, 23),
                                 $urandom_range(0, 59), $urandom_range(0, 59));
            end
            default: begin
                // Days near the month end exercise the roll into the next month.
                r = make_reading($urandom_range(2022, 2101), $urandom_range(1, 12),
                                 $urandom_range(0, 1) ? $urandom_range(28, 31)
                                                      : $urandom_range(1, 31),
                                 $urandom_range(0, 23), $urandom_range(0, 59),
                                 $urandom_range(0, 59));
            end
        endcase
        return r;
    endfunction

    // Sends one reading request, with a random gap before it, and records the
    // stamp it must produce at the edge where it is accepted.
    task automatic apply_reading(t_reading r);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            date_if.valid <= 1'b0;
            @(posedge clk);
        end
        date_if.valid  <= 1'b1;
        date_if.year   <= r.year;
        date_if.month  <= r.month;
        date_if.day    <= r.day;
        date_if.hour   <= r.hour;
        date_if.minute <= r.minute;
        date_if.second <= r.second;
        @(posedge clk);
        while (!date_if.ready) begin
            @(posedge clk);
        end
        expected_stamps.push_back(epoch_of_reading(r, offset_setting));
    endtask

    task automatic wait_drained();
        date_if.valid <= 1'b0;
        while (expected_stamps.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // The offset register is only written with nothing in flight.
    task automatic write_offset(logic [CFG_W-1:0] value);
        wait_drained();
        offset_if.valid <= 1'b1;
        offset_if.data  <= value;
        @(posedge clk);
        while (!offset_if.ready) begin
            @(posedge clk);
        end
        offset_if.valid <= 1'b0;
        offset_setting = value;
    endtask

    task automatic test_field_checks();
        apply_reading(make_reading(2025, 6, 15, 12, 30, 45));
        apply_reading(make_reading(2024, 1, 1, 0, 0, 0));       // first second of the window
        apply_reading(make_reading(2023, 12, 31, 23, 59, 59));  // one second before it
        apply_reading(make_reading(2099, 12, 31, 23, 59, 59));  // last second of the window
        apply_reading(make_reading(2100, 1, 1, 0, 0, 0));       // first second past it
        apply_reading(make_reading(2025, 2, 31, 8, 0, 0));      // rolls into March
        apply_reading(make_reading(2024, 2, 29, 23, 59, 59));   // leap day
        apply_reading(make_reading(2000, 3, 1, 0, 0, 0));       // era boundary
        apply_reading(make_reading(0, 1, 1, 0, 0, 0));          // year before year zero's March
        apply_reading(make_reading(16383, 12, 31, 23, 59, 59)); // all ones year
        apply_reading(make_reading(1970, 1, 1, 0, 0, 0));
        apply_reading(make_reading(2030, 0, 10, 1, 1, 1));
        apply_reading(make_reading(2030, 13, 10, 1, 1, 1));
        apply_reading(make_reading(2030, 15, 10, 1, 1, 1));
        apply_reading(make_reading(2030, 5, 0, 1, 1, 1));
        apply_reading(make_reading(2030, 5, 10, 24, 1, 1));
        apply_reading(make_reading(2030, 5, 31, 31, 63, 63));
        apply_reading(make_reading(2030, 5, 10, 1, 60, 1));
        apply_reading(make_reading(2030, 5, 10, 1, 1, 60));
        apply_reading(make_reading(0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_offset_register();
        write_offset(8'd0);
        apply_reading(make_reading(2024, 1, 1, 0, 0, 0));
        write_offset(OFFSET_MAX);
        apply_reading(make_reading(2099, 12, 31, 23, 59, 59));
        write_offset(OFFSET_MAX + 8'd1);
        apply_reading(make_reading(2050, 7, 4, 10, 20, 30));
        write_offset(8'hFF);
        apply_reading(make_reading(2050, 7, 4, 10, 20, 30));
    endtask

    // A new offset every hundred readings; each write first lets the
    // pipeline run dry, which also keeps the sender waiting for it.
    task automatic test_random_readings(int unsigned src_pct, int unsigned sink_pct,
                                        int unsigned count);
        logic [CFG_W-1:0] offs;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                case ($urandom_range(0, 4))
                    0:       offs = 8'd0;
                    1:       offs = OFFSET_MAX;
                    2:       offs = CFG_W'($urandom_range(OFFSET_MAX + 1, 255));
                    default: offs = CFG_W'($urandom_range(0, OFFSET_MAX));
                endcase
                write_offset(offs);
            end
            apply_reading(random_reading());
        end
    endtask

    always @(posedge clk) begin
        stamp_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge clk) begin : check_stamps
        t_stamp got;
        t_stamp want;
        if (rst_n && stamp_if.valid && stamp_if.ready) begin
            got.fields_ok   = stamp_if.fields_ok;
            got.epoch_ok    = stamp_if.epoch_ok;
            got.utc_epoch   = stamp_if.utc_epoch;
            got.local_epoch = stamp_if.local_epoch;
            if (expected_stamps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: fields_ok=%0b epoch_ok=%0b utc=%0d local=%0d",
                             got.fields_ok, got.epoch_ok, got.utc_epoch, got.local_epoch);
                end
            end else begin
                want = expected_stamps.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected fields_ok=%0b epoch_ok=%0b utc=%0d local=%0d",
                                 want.fields_ok, want.epoch_ok, want.utc_epoch, want.local_epoch);
                        $display("          actual   fields_ok=%0b epoch_ok=%0b utc=%0d local=%0d",
                                 got.fields_ok, got.epoch_ok, got.utc_epoch, got.local_epoch);
                    end
                end
            end
        end
    end

    // Watchdog: any request moving on any channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (date_if.valid && date_if.ready) || (stamp_if.valid && stamp_if.ready)
                || (offset_if.valid && offset_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL civil_date_to_epoch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        offset_setting = OFFSET_BIAS;
        src_idle_pct   = 29;
        sink_idle_pct  = 62;
        rst_n           <= 1'b0;
        date_if.valid   <= 1'b0;
        date_if.year    <= '0;
        date_if.month   <= '0;
        date_if.day     <= '0;
        date_if.hour    <= '0;
        date_if.minute  <= '0;
        date_if.second  <= '0;
        offset_if.valid <= 1'b0;
        offset_if.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_checks();
        test_offset_register();
        test_random_readings(29, 62, 400);
        test_random_readings(62, 29, 400);
        test_random_readings(0, 0, 400);

        wait_drained();
        // Room for any stray result to show up behind the last one.
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASS civil_date_to_epoch");
        end else begin
            $display("FAIL civil_date_to_epoch");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/cde_pkg.sv
hw/rtl/cde_if.sv
hw/rtl/civil_date_to_epoch.sv
hw/rtl/cde_checker.sv
dv/civil_date_to_epoch_tb.sv
